// ===== rtl/htwd_pkg.sv =====
// Shared constants, codes and types of the Huffman tree-walk decoder.
`default_nettype none
package htwd_pkg;

    localparam int SYMBOL_COUNT  = 256;
    localparam int NODE_SLOTS    = 512;
    localparam int MAX_CODE_BITS = 32;

    localparam int NODE_W    = $clog2(NODE_SLOTS);
    localparam int CNT_W     = $clog2(NODE_SLOTS + 1);
    localparam int SYM_W     = 8;
    localparam int SYM_CNT_W = $clog2(SYMBOL_COUNT + 1);
    localparam int LEN_W     = 6;
    localparam int CODE_W    = 32;
    localparam int IDX_W     = $clog2(CODE_W);
    localparam int BYTE_BITS = 8;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_DECODE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [SYM_W-1:0]  sym;
    } node_t;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        node_t             wr_data;
    } mem_req_t;

    typedef struct packed {
        logic             push;
        logic             direct;
        logic             flush;
        logic [SYM_W-1:0] sym;
        logic             sym_valid;
        logic [1:0]       status;
    } res_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/htwd_node_ram.sv =====
// Node store: one synchronous memory of child pointers and leaf symbols.
`default_nettype none
module htwd_node_ram
    import htwd_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output node_t         rd_data
);

    node_t mem [NODE_SLOTS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/htwd_walker.sv =====
// Sequencer that clears the tree, inserts codes and walks compressed bytes.
`default_nettype none
module htwd_walker
    import htwd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          action,
    input  wire logic [SYM_W-1:0]    symbol,
    input  wire logic [LEN_W-1:0]    code_length,
    input  wire logic [CODE_W-1:0]   code_bits,
    input  wire logic [BYTE_BITS-1:0] data_byte,
    input  wire node_t               rd_data,
    output logic                     busy,
    output mem_req_t                 req,
    output res_cmd_t                 cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_LOAD  = 2'd1;
    localparam logic [1:0] S_DEC   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    localparam logic [1:0] SRC_ROOT = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_NEW  = 2'd2;

    logic [1:0]        state_reg, state_next;
    node_t             root_reg, root_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [NODE_W-1:0] walk_reg, walk_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [1:0]        src_reg, src_next;
    logic              check_reg, check_next;
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic [CODE_W-1:0] bits_reg, bits_next;
    logic [SYM_W-1:0]  sym_reg, sym_next;

    node_t             w;
    node_t             e;
    node_t             upd;
    logic              cur_bit;
    logic              leaf;
    logic [NODE_W-1:0] slot;
    logic [NODE_W-1:0] new_idx;
    logic [LEN_W-1:0]  eff_len;

    assign busy    = (state_reg != S_IDLE);
    assign cur_bit = bits_reg[IDX_W'(cnt_reg - LEN_W'(1))];
    assign new_idx = used_reg[NODE_W-1:0];
    assign eff_len = (code_length > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                           : code_length;

    always_comb
    begin
        case (src_reg)
            SRC_ROOT: w = root_reg;
            SRC_MEM:  w = rd_data;
            default:  w = '0;
        endcase
    end

    assign leaf = check_reg && (w.left == '0) && (w.right == '0);
    assign e    = leaf ? root_reg : w;
    assign slot = cur_bit ? e.right : e.left;

    always_comb
    begin
        state_next = state_reg;
        root_next  = root_reg;
        used_next  = used_reg;
        walk_next  = walk_reg;
        cur_next   = cur_reg;
        src_next   = src_reg;
        check_next = check_reg;
        cnt_next   = cnt_reg;
        bits_next  = bits_reg;
        sym_next   = sym_reg;
        req        = '0;
        cmd        = '0;
        upd        = w;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            root_next  = '0;
                            used_next  = CNT_W'(1);
                            walk_next  = '0;
                            cmd.direct = 1'b1;
                            cmd.status = ST_OK;
                        end
                        ACT_LOAD:
                        begin
                            if ({1'b0, symbol} < SYM_CNT_W'(SYMBOL_COUNT))
                            begin
                                cur_next   = '0;
                                src_next   = SRC_ROOT;
                                check_next = 1'b0;
                                cnt_next   = eff_len;
                                bits_next  = code_bits;
                                sym_next   = symbol;
                                state_next = S_LOAD;
                            end
                            else
                            begin
                                cmd.direct = 1'b1;
                                cmd.status = ST_OK;
                            end
                        end
                        ACT_DECODE:
                        begin
                            cur_next    = walk_reg;
                            src_next    = (walk_reg == '0) ? SRC_ROOT : SRC_MEM;
                            req.rd_en   = (walk_reg != '0);
                            req.rd_addr = walk_reg;
                            check_next  = 1'b0;
                            cnt_next    = LEN_W'(BYTE_BITS);
                            bits_next   = CODE_W'(data_byte);
                            state_next  = S_DEC;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                if (cnt_reg == '0)
                begin
                    upd.sym    = sym_reg;
                    cmd.direct = 1'b1;
                    cmd.status = ST_OK;
                    state_next = S_IDLE;
                    if (cur_reg == '0)
                    begin
                        root_next = upd;
                    end
                    else
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = cur_reg;
                        req.wr_data = upd;
                    end
                end
                else if (slot != '0)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = slot;
                    cur_next    = slot;
                    src_next    = SRC_MEM;
                    cnt_next    = cnt_reg - LEN_W'(1);
                end
                else if (used_reg == CNT_W'(NODE_SLOTS))
                begin
                    // A freshly made node still has to reach the store.
                    req.wr_en   = (cur_reg != '0);
                    req.wr_addr = cur_reg;
                    req.wr_data = w;
                    cmd.direct  = 1'b1;
                    cmd.status  = ST_FULL;
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (cur_bit)
                    begin
                        upd.right = new_idx;
                    end
                    else
                    begin
                        upd.left = new_idx;
                    end
                    if (cur_reg == '0)
                    begin
                        root_next = upd;
                    end
                    else
                    begin
                        req.wr_en   = 1'b1;
                        req.wr_addr = cur_reg;
                        req.wr_data = upd;
                    end
                    cur_next  = new_idx;
                    src_next  = SRC_NEW;
                    used_next = used_reg + CNT_W'(1);
                    cnt_next  = cnt_reg - LEN_W'(1);
                end
            end

            S_DEC:
            begin
                if (leaf)
                begin
                    cmd.push      = 1'b1;
                    cmd.sym       = w.sym;
                    cmd.sym_valid = 1'b1;
                    cmd.status    = ST_OK;
                end
                if (cnt_reg == '0)
                begin
                    walk_next  = leaf ? '0 : cur_reg;
                    state_next = S_FLUSH;
                end
                else if (slot != '0)
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = slot;
                    cur_next    = slot;
                    src_next    = SRC_MEM;
                    check_next  = 1'b1;
                    cnt_next    = cnt_reg - LEN_W'(1);
                end
                else if (!leaf)
                begin
                    cmd.push   = 1'b1;
                    cmd.status = ST_MISSING;
                    cur_next   = '0;
                    src_next   = SRC_ROOT;
                    check_next = 1'b0;
                    cnt_next   = cnt_reg - LEN_W'(1);
                end
                else
                begin
                    // The symbol beat goes out now; the missing child is retried from the root.
                    cur_next   = '0;
                    src_next   = SRC_ROOT;
                    check_next = 1'b0;
                end
            end

            S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            root_reg  <= '0;
            used_reg  <= CNT_W'(1);
            walk_reg  <= '0;
            cur_reg   <= '0;
            src_reg   <= SRC_ROOT;
            check_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            root_reg  <= root_next;
            used_reg  <= used_next;
            walk_reg  <= walk_next;
            cur_reg   <= cur_next;
            src_reg   <= src_next;
            check_reg <= check_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        sym_reg  <= sym_next;
    end

endmodule
`default_nettype wire

// ===== rtl/htwd_result.sv =====
// Result stage that holds back one beat so that the final beat of an item carries last.
`default_nettype none
module htwd_result
    import htwd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire res_cmd_t cmd,
    output logic          out_valid,
    output logic [SYM_W-1:0] out_symbol,
    output logic          symbol_valid,
    output logic [1:0]    status,
    output logic          last
);

    logic             valid_reg, valid_next;
    logic [SYM_W-1:0] osym_reg, osym_next;
    logic             osv_reg, osv_next;
    logic [1:0]       ost_reg, ost_next;
    logic             olast_reg, olast_next;
    logic             pend_reg, pend_next;
    logic [SYM_W-1:0] psym_reg, psym_next;
    logic             psv_reg, psv_next;
    logic [1:0]       pst_reg, pst_next;

    always_comb
    begin
        valid_next = 1'b0;
        osym_next  = osym_reg;
        osv_next   = osv_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;
        pend_next  = pend_reg;
        psym_next  = psym_reg;
        psv_next   = psv_reg;
        pst_next   = pst_reg;

        if (cmd.direct)
        begin
            valid_next = 1'b1;
            osym_next  = cmd.sym;
            osv_next   = cmd.sym_valid;
            ost_next   = cmd.status;
            olast_next = 1'b1;
        end
        else if (cmd.push)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                osym_next  = psym_reg;
                osv_next   = psv_reg;
                ost_next   = pst_reg;
                olast_next = 1'b0;
            end
            pend_next = 1'b1;
            psym_next = cmd.sym;
            psv_next  = cmd.sym_valid;
            pst_next  = cmd.status;
        end
        else if (cmd.flush)
        begin
            if (pend_reg)
            begin
                valid_next = 1'b1;
                osym_next  = psym_reg;
                osv_next   = psv_reg;
                ost_next   = pst_reg;
                olast_next = 1'b1;
            end
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        osym_reg  <= osym_next;
        osv_reg   <= osv_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
        psym_reg  <= psym_next;
        psv_reg   <= psv_next;
        pst_reg   <= pst_next;
    end

    assign out_valid    = valid_reg;
    assign out_symbol   = osym_reg;
    assign symbol_valid = osv_reg;
    assign status       = ost_reg;
    assign last         = olast_reg;

endmodule
`default_nettype wire

// ===== rtl/huffman_tree_walk_decoder.sv =====
// Top level of the Huffman tree-walk decoder: node store, walker and result stage.
//
// Channel   Handshake            Payload
// input     start, busy          action, symbol, code_length, code_bits, data_byte
// result    out_valid (strobe)   out_symbol, symbol_valid, status, last
//
// A beat is taken when start is high and busy is low.
// A load descends one tree level per cycle.
// A decode does one node read a cycle through the single read port, and retries a bit
// from the root when a missing child follows a leaf in the same byte.
// A decode beat is held until the next one is found or the byte ends, so that the
// final beat carries last; the receiver cannot stall.
// After reset the tree is a bare root and the walk stands at the root.
`default_nettype none
module huffman_tree_walk_decoder
    import htwd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           action,
    input  wire logic [SYM_W-1:0]     symbol,
    input  wire logic [LEN_W-1:0]     code_length,
    input  wire logic [CODE_W-1:0]    code_bits,
    input  wire logic [BYTE_BITS-1:0] data_byte,
    output logic                      out_valid,
    output logic [SYM_W-1:0]          out_symbol,
    output logic                      symbol_valid,
    output logic [1:0]                status,
    output logic                      last
);

    mem_req_t req;
    node_t    rd_data;
    res_cmd_t cmd;

    htwd_node_ram u_ram (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    htwd_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .symbol      (symbol),
        .code_length (code_length),
        .code_bits   (code_bits),
        .data_byte   (data_byte),
        .rd_data     (rd_data),
        .busy        (busy),
        .req         (req),
        .cmd         (cmd)
    );

    htwd_result u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_symbol   (out_symbol),
        .symbol_valid (symbol_valid),
        .status       (status),
        .last         (last)
    );

    a_decode_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_DECODE) |=> busy)
        else $error("decode beat accepted without the walker going busy");

    a_one_port_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.rd_en && req.wr_en))
        else $error("node store read and written in the same cycle");

    a_open_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> busy)
        else $error("non-final result beat while the walker is idle");

    a_symbol_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && symbol_valid) |-> (status == ST_OK))
        else $error("decoded symbol beat carries an error status");

endmodule
`default_nettype wire

// ===== sim/huffman_tree_walk_decoder_tb.sv =====
// Self-checking testbench for the Huffman tree-walk decoder: random trees, loads and decodes.
module huffman_tree_walk_decoder_tb;
    import htwd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 24;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]           action;
        logic [SYM_W-1:0]     symbol;
        logic [LEN_W-1:0]     code_length;
        logic [CODE_W-1:0]    code_bits;
        logic [BYTE_BITS-1:0] data_byte;
        logic                 drain;
        logic [1:0]           idle_after;
    } command_t;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             symbol_valid;
        logic [1:0]       status;
        logic             last;
    } beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           action = ACT_CLEAR;
    logic [SYM_W-1:0]     symbol = '0;
    logic [LEN_W-1:0]     code_length = '0;
    logic [CODE_W-1:0]    code_bits = '0;
    logic [BYTE_BITS-1:0] data_byte = '0;
    logic                 busy;
    logic                 out_valid;
    logic [SYM_W-1:0]     out_symbol;
    logic                 symbol_valid;
    logic [1:0]           status;
    logic                 last;

    command_t commands_pending[$];
    beat_t    results_due[$];
    command_t in_flight;
    beat_t    oldest_due;
    int       gap_left;
    int       gap_pct;
    logic     drain_next;

    logic [NODE_W-1:0] model_left[NODE_SLOTS];
    logic [NODE_W-1:0] model_right[NODE_SLOTS];
    logic [SYM_W-1:0]  model_sym[NODE_SLOTS];
    int                model_nodes;
    logic [NODE_W-1:0] model_walk;

    int error_count;
    int cycle_count;
    int commands_taken;
    int beats_seen;
    int symbols_seen;
    int missing_seen;
    int full_seen;

    huffman_tree_walk_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .symbol       (symbol),
        .code_length  (code_length),
        .code_bits    (code_bits),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_symbol   (out_symbol),
        .symbol_valid (symbol_valid),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic push_item(input logic [1:0] act, input logic [SYM_W-1:0] sym,
                             input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] bits,
                             input logic [BYTE_BITS-1:0] data);
        command_t c;
        begin
            c.action      = act;
            c.symbol      = sym;
            c.code_length = len;
            c.code_bits   = bits;
            c.data_byte   = data;
            c.drain       = drain_next;
            if (commands_pending.size() >= 150)
                gap_pct = 0;
            if ($urandom_range(0, 99) < gap_pct)
                c.idle_after = 2'($urandom_range(1, 3));
            else
                c.idle_after = 2'd0;
            drain_next = 1'b0;
            commands_pending.push_back(c);
        end
    endtask

    task automatic reset_tree();
        begin
            model_left[0]  = '0;
            model_right[0] = '0;
            model_sym[0]   = '0;
            model_nodes    = 1;
            model_walk     = '0;
        end
    endtask

    task automatic predict_beats(input command_t c);
        beat_t             found[8];
        beat_t             b;
        int                n;
        int                len;
        logic              bit_v;
        logic [1:0]        st;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] nxt;
        begin
            n = 0;
            case (c.action)
                ACT_CLEAR:
                begin
                    reset_tree();
                    found[0] = '{symbol: '0, symbol_valid: 1'b0, status: ST_OK, last: 1'b0};
                    n = 1;
                end
                ACT_LOAD:
                begin
                    st = ST_OK;
                    if (int'(c.symbol) < SYMBOL_COUNT)
                    begin
                        len = (int'(c.code_length) > MAX_CODE_BITS) ? MAX_CODE_BITS
                                                                    : int'(c.code_length);
                        node = '0;
                        for (int i = len - 1; i >= 0; i--)
                        begin
                            if (st == ST_OK)
                            begin
                                bit_v = (i < CODE_W) ? c.code_bits[i] : 1'b0;
                                nxt = bit_v ? model_right[node] : model_left[node];
                                if (nxt == '0)
                                begin
                                    if (model_nodes >= NODE_SLOTS)
                                        st = ST_FULL;
                                    else
                                    begin
                                        nxt = NODE_W'(model_nodes);
                                        model_left[nxt]  = '0;
                                        model_right[nxt] = '0;
                                        model_sym[nxt]   = '0;
                                        if (bit_v)
                                            model_right[node] = nxt;
                                        else
                                            model_left[node] = nxt;
                                        model_nodes++;
                                    end
                                end
                                if (st == ST_OK)
                                    node = nxt;
                            end
                        end
                        if (st == ST_OK)
                            model_sym[node] = c.symbol;
                    end
                    found[0] = '{symbol: '0, symbol_valid: 1'b0, status: st, last: 1'b0};
                    n = 1;
                end
                ACT_DECODE:
                begin
                    for (int j = BYTE_BITS - 1; j >= 0; j--)
                    begin
                        nxt = c.data_byte[j] ? model_right[model_walk] : model_left[model_walk];
                        if (nxt == '0)
                        begin
                            found[n] = '{symbol: '0, symbol_valid: 1'b0, status: ST_MISSING,
                                         last: 1'b0};
                            n++;
                            model_walk = '0;
                        end
                        else if (model_left[nxt] == '0 && model_right[nxt] == '0)
                        begin
                            found[n] = '{symbol: model_sym[nxt], symbol_valid: 1'b1,
                                         status: ST_OK, last: 1'b0};
                            n++;
                            model_walk = '0;
                        end
                        else
                            model_walk = nxt;
                    end
                end
                default:
                    ;
            endcase
            for (int k = 0; k < n; k++)
            begin
                b = found[k];
                b.last = (k == n - 1);
                results_due.push_back(b);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        begin
            if (want != got)
            begin
                error_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            action      <= ACT_CLEAR;
            symbol      <= '0;
            code_length <= '0;
            code_bits   <= '0;
            data_byte   <= '0;
            gap_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_beats(in_flight);
                commands_taken++;
            end
            if (start && busy)
                start <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (commands_pending.size() != 0
                     && !(commands_pending[0].drain && (results_due.size() != 0 || busy)))
            begin
                in_flight = commands_pending.pop_front();
                action      <= in_flight.action;
                symbol      <= in_flight.symbol;
                code_length <= in_flight.code_length;
                code_bits   <= in_flight.code_bits;
                data_byte   <= in_flight.data_byte;
                start       <= 1'b1;
                gap_left = in_flight.idle_after;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid)
        begin
            beats_seen++;
            if (symbol_valid)
                symbols_seen++;
            if (status == ST_MISSING)
                missing_seen++;
            if (status == ST_FULL)
                full_seen++;
            if (results_due.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected beat, expected none, actual symbol %0d valid %0d status %0d last %0d",
                         $time, out_symbol, symbol_valid, status, last);
            end
            else
            begin
                oldest_due = results_due.pop_front();
                check_field("out_symbol", oldest_due.symbol, out_symbol);
                check_field("symbol_valid", oldest_due.symbol_valid, symbol_valid);
                check_field("status", oldest_due.status, status);
                check_field("last", oldest_due.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d commands and %0d beats still outstanding",
                     $time, commands_pending.size(), results_due.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int               lens[16];
        logic [CODE_W-1:0] vals[16];
        int               n;
        int               k;
        int               pick;
        int               off;
        int               skip;
        int               kind;
        int               idx;

        error_count = 0;
        cycle_count = 0;
        commands_taken = 0;
        beats_seen = 0;
        symbols_seen = 0;
        missing_seen = 0;
        full_seen = 0;
        gap_pct = 30;
        drain_next = 1'b0;
        reset_tree();

        push_item(ACT_DECODE, 8'h3C, 6'd5, 32'h0, 8'h00);
        push_item(ACT_NONE, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        push_item(ACT_LOAD, 8'hA5, 6'd0, 32'hFFFF_FFFF, 8'h00);
        push_item(ACT_LOAD, 8'h00, 6'd1, 32'h0, 8'hFF);
        push_item(ACT_LOAD, 8'hFF, 6'd1, 32'h1, 8'h00);
        push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'h00);
        push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF);
        push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'hA5);
        push_item(ACT_LOAD, 8'h5A, 6'd63, 32'hFFFF_FFFF, 8'h00);
        repeat (4) push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'hFF);
        push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'h7F);
        push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'h00);
        push_item(ACT_LOAD, 8'h80, 6'd32, 32'h0, 8'h00);
        push_item(ACT_CLEAR, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        push_item(ACT_LOAD, 8'h11, 6'd2, 32'h1, 8'h00);
        push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'h40);
        push_item(ACT_DECODE, 8'h00, 6'd0, 32'h0, 8'h60);

        kind = 99;
        drain_next = 1'b1;
        while (commands_pending.size() < 175)
        begin
            if ($urandom_range(0, 5) == 0)
                drain_next = 1'b1;
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 30;
                default: gap_pct = 70;
            endcase
            if (kind < 0 || kind >= 88)
            begin
                push_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
                repeat (22) push_item(ACT_LOAD, $urandom, 6'd32, $urandom, $urandom);
                repeat (2) push_item(ACT_DECODE, $urandom, $urandom, $urandom, $urandom);
                drain_next = 1'b1;
            end
            else if (kind < 55)
            begin
                push_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
                k = $urandom_range(2, 12);
                lens[0] = 0;
                vals[0] = '0;
                n = 1;
                while (n < k)
                begin
                    pick = $urandom_range(0, n - 1);
                    if (lens[pick] < 10)
                    begin
                        lens[n] = lens[pick] + 1;
                        vals[n] = (vals[pick] << 1) | 32'h1;
                        lens[pick]++;
                        vals[pick] = vals[pick] << 1;
                        n++;
                    end
                end
                off = $urandom_range(0, n - 1);
                skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : n;
                for (int j = 0; j < n; j++)
                begin
                    idx = (off + j) % n;
                    if (idx != skip)
                        push_item(ACT_LOAD, $urandom, LEN_W'(lens[idx]), vals[idx], $urandom);
                end
                repeat ($urandom_range(3, 8))
                    push_item(ACT_DECODE, $urandom, $urandom, $urandom, $urandom);
            end
            else if (kind < 70)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_item(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
                repeat ($urandom_range(2, 4))
                    push_item(ACT_LOAD, $urandom, LEN_W'($urandom_range(16, 32)), $urandom,
                              $urandom);
                repeat ($urandom_range(4, 8))
                    push_item(ACT_DECODE, $urandom, $urandom, $urandom, $urandom);
            end
            else if (kind < 80)
            begin
                repeat ($urandom_range(4, 8))
                    push_item(2'($urandom_range(0, 3)), $urandom,
                              LEN_W'($urandom_range(0, 63)), $urandom, $urandom);
            end
            else
            begin
                repeat ($urandom_range(2, 5))
                    push_item(ACT_LOAD, $urandom, LEN_W'($urandom_range(1, 6)), $urandom,
                              $urandom);
                repeat ($urandom_range(2, 5))
                    push_item(ACT_DECODE, $urandom, $urandom, $urandom, $urandom);
            end
            kind = $urandom_range(0, 99);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (commands_pending.size() != 0 || start)
            @(posedge clk);
        while (results_due.size() != 0 || busy)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (results_due.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected beats never arrived", $time, results_due.size());
        end
        $display("Ran %0d commands over clears, code loads, store overflow and decodes.",
                 commands_taken);
        $display("Saw %0d result beats: %0d symbols, %0d missing-child and %0d store-full.",
                 beats_seen, symbols_seen, missing_seen, full_seen);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
